// ===== hdl/perl_pkg.sv =====
`timescale 1ns / 1ps

package perl_pkg;

  // Fixed-point formats.
  localparam int FracW  = 16;                // fraction bits of a coordinate
  localparam int WghtW  = FracW + 1;         // fade weight, unsigned Q0.16, 0..1.0
  localparam int OffW   = FracW + 2;         // corner offset, signed Q16
  localparam int DotW   = OffW + 1;          // corner dot product, signed Q16
  localparam int OutW   = 18;                // noise result, signed Q2.16

  // Fade polynomial 6t^5 - 15t^4 + 10t^3.
  localparam int FadeA  = 6;
  localparam int FadeB  = 15;
  localparam int FadeC  = 10;
  localparam logic [WghtW-1:0] FadeOne = WghtW'(1) << FracW;

  // Output saturation limits.
  localparam logic signed [DotW-1:0] OutMax = DotW'((1 << (OutW - 1)) - 1);
  localparam logic signed [DotW-1:0] OutMin = -DotW'(1 << (OutW - 1));

  // Gradient codes: the four diagonals.
  localparam logic [1:0] GradPP = 2'd0;      // ( 1,  1)
  localparam logic [1:0] GradNP = 2'd1;      // (-1,  1)
  localparam logic [1:0] GradNN = 2'd2;      // (-1, -1)
  localparam logic [1:0] GradPN = 2'd3;      // ( 1, -1)

  // Dot product of a diagonal gradient with a corner offset.
  function automatic logic signed [DotW-1:0] corner_dot(
    input logic [1:0]               grad,
    input logic signed [OffW-1:0]   dx,
    input logic signed [OffW-1:0]   dy
  );
    logic signed [DotW-1:0] ex;
    logic signed [DotW-1:0] ey;
    logic signed [DotW-1:0] res;
    ex = DotW'(dx);
    ey = DotW'(dy);
    case (grad)
      GradPP:  res = ex + ey;
      GradNP:  res = ey - ex;
      GradNN:  res = -ex - ey;
      GradPN:  res = ex - ey;
      default: res = ex + ey;
    endcase
    return res;
  endfunction

endpackage

// ===== hdl/perl_fade.sv =====
`timescale 1ns / 1ps

// Quintic fade curve as a five-stage pipeline, one multiplier per stage.
module perl_fade import perl_pkg::*; (
  input  logic             clk_i,
  input  logic [FracW-1:0] f_i,
  output logic [WghtW-1:0] w_o
);

  localparam int PW  = 2 * FracW + 4;        // polynomial p, Q32, at most 10 * 2^32
  localparam int R1W = 2 * FracW + 2;        // p * f in Q32, below 2.02 * 2^32
  localparam int R2W = 2 * FracW + 1;        // p * f^2 in Q32, below 1.2 * 2^32
  localparam int R3W = WghtW + 1;

  logic [FracW-1:0]   f_q [4];
  logic [2*FracW-1:0] sq_q;
  logic [PW-1:0]      p_d, p_q;
  logic [R1W-1:0]     r1_d, r1_q;
  logic [R2W-1:0]     r2_d, r2_q;
  logic [PW+FracW-1:0]  m1;
  logic [R1W+FracW-1:0] m2;
  logic [R2W+FracW:0]   m3;
  logic [R3W-1:0]     r3;
  logic [WghtW-1:0]   w_d, w_q;

  // The polynomial 6f^2 - 15f + 10 in Q32; it stays positive over the whole fraction range.
  assign p_d = PW'(sq_q) * PW'(FadeA) + (PW'(FadeC) << (2 * FracW))
             - ((PW'(f_q[0]) * PW'(FadeB)) << FracW);

  // Three successive multiplications by the fraction; the first two are truncated to Q32.
  assign m1   = (PW + FracW)'(p_q) * (PW + FracW)'(f_q[1]);
  assign r1_d = R1W'(m1 >> FracW);
  assign m2   = (R1W + FracW)'(r1_q) * (R1W + FracW)'(f_q[2]);
  assign r2_d = R2W'(m2 >> FracW);

  // Last product rounds half up to Q0.16 and is clamped to one.
  assign m3  = (R2W + FracW + 1)'(r2_q) * (R2W + FracW + 1)'(f_q[3])
             + ((R2W + FracW + 1)'(1) << (2 * FracW - 1));
  assign r3  = R3W'(m3 >> (2 * FracW));
  assign w_d = (r3 > R3W'(FadeOne)) ? FadeOne : WghtW'(r3);

  // Pipeline registers; the fraction travels alongside.
  always_ff @(posedge clk_i) begin
    sq_q   <= (2 * FracW)'(f_i) * (2 * FracW)'(f_i);
    f_q[0] <= f_i;
    f_q[1] <= f_q[0];
    f_q[2] <= f_q[1];
    f_q[3] <= f_q[2];
    p_q    <= p_d;
    r1_q   <= r1_d;
    r2_q   <= r2_d;
    w_q    <= w_d;
  end

  assign w_o = w_q;

endmodule

// ===== hdl/perl_lerp.sv =====
`timescale 1ns / 1ps

// Two-stage linear blend a + round((b - a) * w / 2^16), rounding half up.
module perl_lerp import perl_pkg::*; (
  input  logic                   clk_i,
  input  logic [WghtW-1:0]       w_i,
  input  logic signed [DotW-1:0] a_i,
  input  logic signed [DotW-1:0] b_i,
  output logic signed [DotW-1:0] y_o
);

  localparam int DiffW = DotW + 1;
  localparam int ProdW = DiffW + WghtW + 1;

  logic signed [DiffW-1:0] diff;
  logic signed [ProdW-1:0] prod_d, prod_q;
  logic signed [ProdW-1:0] rnd;
  logic signed [DotW-1:0]  a_q;
  logic signed [DotW-1:0]  y_d, y_q;

  // First stage: weighted difference.
  assign diff   = DiffW'(b_i) - DiffW'(a_i);
  assign prod_d = ProdW'(diff) * ProdW'(signed'({1'b0, w_i}));

  // Second stage: round and add back; the result lies between a and b.
  assign rnd = (prod_q + (ProdW'(1) <<< (FracW - 1))) >>> FracW;
  assign y_d = a_q + DotW'(rnd);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    a_q    <= a_i;
    y_q    <= y_d;
  end

  assign y_o = y_q;

endmodule

// ===== hdl/perlin_noise_2d_sample.sv =====
`timescale 1ns / 1ps

// 2D gradient noise sampler.
// A request carries one sample point, x_coord_i and y_coord_i in signed Q16.16,
// and is taken at a rising edge where start_i is high and busy_o is low.
// busy_o is always low: the pipeline takes a new request in every cycle.
// Each request yields exactly one noise_value_o in signed Q2.16, saturated,
// shown for one cycle with done_o high; results leave in request order.
// The result comes from the output register of the last blend level; done_o is
// high in the same cycle as that result, which is taken at the rising edge that
// ends the cycle. Throughput is one point per cycle.
// The depth is set by the fade curve, which takes five stages: the square, the
// polynomial and three chained multiplications by the fraction, one per stage.
// Two blend levels of two stages each follow.
// Reset clears the valid bits only; no result appears for anything in flight.
// The receiver cannot stall, so the pipeline never holds.
module perlin_noise_2d_sample import perl_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic signed [31:0]    x_coord_i,
  input  logic signed [31:0]    y_coord_i,
  output logic                  busy_o,
  output logic                  done_o,
  output logic signed [OutW-1:0] noise_value_o
);

  localparam int Depth  = 9;                 // register stages from request to result
  localparam int DotDly = 5;                 // dot products wait for the fade weights

  typedef struct packed {
    logic signed [DotW-1:0] d00;
    logic signed [DotW-1:0] d01;
    logic signed [DotW-1:0] d10;
    logic signed [DotW-1:0] d11;
  } dots_t;

  logic                   take;
  logic [Depth-1:0]       valid_d, valid_q;
  logic [FracW-1:0]       fx, fy;
  logic [1:0]             base;
  logic signed [OffW-1:0] x0, y0, x1, y1;
  dots_t                  dots_d;
  dots_t                  dots_q [DotDly];
  logic [WghtW-1:0]       u_w, v_w;
  logic [WghtW-1:0]       u_q [2];
  logic signed [DotW-1:0] left, right, mix;

  assign busy_o = 1'b0;
  assign take   = start_i && !busy_o;

  // Valid bits travel with the data.
  assign valid_d = {valid_q[Depth-2:0], take};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Split into cell and fraction; the gradient base is the cell sum mod 4.
  assign fx   = x_coord_i[FracW-1:0];
  assign fy   = y_coord_i[FracW-1:0];
  assign base = x_coord_i[FracW+1:FracW] + y_coord_i[FracW+1:FracW];
  assign x0   = signed'({2'b00, fx});
  assign y0   = signed'({2'b00, fy});
  assign x1   = signed'({2'b11, fx});
  assign y1   = signed'({2'b11, fy});

  // Corner dot products.
  always_comb begin
    dots_d.d00 = corner_dot(base, x0, y0);
    dots_d.d01 = corner_dot(base + 2'd1, x0, y1);
    dots_d.d10 = corner_dot(base + 2'd1, x1, y0);
    dots_d.d11 = corner_dot(base + 2'd2, x1, y1);
  end

  // Delay lines that line the dot products up with the fade weights and the x weight up with the last blend.
  always_ff @(posedge clk_i) begin
    dots_q[0] <= dots_d;
    for (int i = 1; i < DotDly; i++) begin
      dots_q[i] <= dots_q[i-1];
    end
    u_q[0] <= u_w;
    u_q[1] <= u_q[0];
  end

  // Fade weights for both axes.
  perl_fade u_fade_x (
    .clk_i (clk_i),
    .f_i   (fx),
    .w_o   (u_w)
  );

  perl_fade u_fade_y (
    .clk_i (clk_i),
    .f_i   (fy),
    .w_o   (v_w)
  );

  // Blend along y on both edges, then along x.
  perl_lerp u_lerp_left (
    .clk_i (clk_i),
    .w_i   (v_w),
    .a_i   (dots_q[DotDly-1].d00),
    .b_i   (dots_q[DotDly-1].d01),
    .y_o   (left)
  );

  perl_lerp u_lerp_right (
    .clk_i (clk_i),
    .w_i   (v_w),
    .a_i   (dots_q[DotDly-1].d10),
    .b_i   (dots_q[DotDly-1].d11),
    .y_o   (right)
  );

  perl_lerp u_lerp_mix (
    .clk_i (clk_i),
    .w_i   (u_q[1]),
    .a_i   (left),
    .b_i   (right),
    .y_o   (mix)
  );

  // Saturate to Q2.16.
  always_comb begin
    if (mix > OutMax) begin
      noise_value_o = OutW'(OutMax);
    end else if (mix < OutMin) begin
      noise_value_o = OutW'(OutMin);
    end else begin
      noise_value_o = OutW'(mix);
    end
  end

  assign done_o = valid_q[Depth-1];

  // The block never refuses a request.
  a_never_busy : assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy_o raised");

  // A request entering the pipeline reaches the next stage.
  a_stage_moves : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[0] |=> valid_q[1])
    else $error("item lost in the first stage");

  // The fade weight never exceeds one.
  a_fade_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[4] |-> (u_w <= FadeOne && v_w <= FadeOne))
    else $error("fade weight above one");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import perl_pkg::*;

  // Cycles without any accepted request or result before the run is abandoned.
  localparam int unsigned StallLimit = 5000;
  // Cycles allowed after the last expected result has arrived.
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned ItemsPerPhase = 300;

  // Keeps the expected noise values in request order and checks each result.
  class noise_scoreboard;
    logic signed [OutW-1:0] expected_noise[$];
    int unsigned failures;

    function new();
      failures = 0;
    endfunction

    // Quintic fade weight of a 16-bit fraction, unsigned Q0.16.
    static function longint unsigned fade_weight(longint unsigned f);
      longint unsigned p;
      longint unsigned r1;
      longint unsigned r2;
      longint unsigned r3;
      p  = 6 * f * f + 10 * (64'd1 << 32) - 15 * 64'd65536 * f;
      r1 = (p * f) >> 16;
      r2 = (r1 * f) >> 16;
      r3 = (r2 * f + (64'd1 << 31)) >> 32;
      if (r3 > 64'd65536) begin
        r3 = 64'd65536;
      end
      return r3;
    endfunction

    // Dot product of a diagonal gradient with the offset to a corner.
    static function longint grad_dot(logic [1:0] grad, longint dx, longint dy);
      case (grad)
        GradPP:  return dx + dy;
        GradNP:  return dy - dx;
        GradNN:  return -dx - dy;
        default: return dx - dy;
      endcase
    endfunction

    // Linear blend with a Q0.16 weight, rounding half up.
    static function longint blend_q16(longint unsigned w, longint a, longint b);
      longint prod;
      prod = (b - a) * longint'(w) + 64'sd32768;
      return a + (prod >>> 16);
    endfunction

    // Noise value expected for one sample point.
    static function logic signed [OutW-1:0] noise_at(logic [31:0] x, logic [31:0] y);
      logic [1:0]      base;
      longint          x0;
      longint          y0;
      longint          x1;
      longint          y1;
      longint          d00;
      longint          d01;
      longint          d10;
      longint          d11;
      longint          left_edge;
      longint          right_edge;
      longint          res;
      longint unsigned u;
      longint unsigned v;
      base = x[17:16] + y[17:16];
      x0   = longint'(x[15:0]);
      y0   = longint'(y[15:0]);
      x1   = x0 - 65536;
      y1   = y0 - 65536;
      d00  = grad_dot(base, x0, y0);
      d01  = grad_dot(base + 2'd1, x0, y1);
      d10  = grad_dot(base + 2'd1, x1, y0);
      d11  = grad_dot(base + 2'd2, x1, y1);
      u    = fade_weight(longint'(x[15:0]));
      v    = fade_weight(longint'(y[15:0]));
      // The left and right edges blend along y, then the two blend along x.
      left_edge  = blend_q16(v, d00, d01);
      right_edge = blend_q16(v, d10, d11);
      res        = blend_q16(u, left_edge, right_edge);
      if (res > 131071) begin
        res = 131071;
      end
      if (res < -131072) begin
        res = -131072;
      end
      return res[OutW-1:0];
    endfunction

    function void note_request(logic [31:0] x, logic [31:0] y);
      expected_noise.push_back(noise_at(x, y));
    endfunction

    function void check_noise(logic signed [OutW-1:0] actual);
      logic signed [OutW-1:0] want;
      if (expected_noise.size() == 0) begin
        $error("noise_value: unexpected result %0d", actual);
        failures++;
        return;
      end
      want = expected_noise.pop_front();
      if (actual !== want) begin
        $error("noise_value: expected %0d, actual %0d", want, actual);
        failures++;
      end
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   start_i;
  logic signed [31:0]     x_coord_i;
  logic signed [31:0]     y_coord_i;
  logic                   busy_o;
  logic                   done_o;
  logic signed [OutW-1:0] noise_value_o;

  noise_scoreboard sb;
  int unsigned     idle_pct;
  int unsigned     quiet_cycles;

  perlin_noise_2d_sample DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .x_coord_i     (x_coord_i),
    .y_coord_i     (y_coord_i),
    .busy_o        (busy_o),
    .done_o        (done_o),
    .noise_value_o (noise_value_o)
  );

  always #5 clk_i = ~clk_i;

  // Note accepted requests and check results at each rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && start_i && !busy_o) begin
      sb.note_request(x_coord_i, y_coord_i);
    end
    if (rst_ni && done_o) begin
      sb.check_noise(noise_value_o);
    end
  end

  // Abandon the run if nothing moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("tb_top: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Issue one request, idling the sender at random beforehand.
  task automatic send_point(logic [31:0] x, logic [31:0] y);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      start_i <= 1'b0;
    end
    @(negedge clk_i);
    start_i   <= 1'b1;
    x_coord_i <= x;
    y_coord_i <= y;
    do @(posedge clk_i); while (busy_o);
  endtask

  // A fully random coordinate, or one with an edge, half or random fraction.
  function automatic logic [31:0] random_coord();
    logic [15:0] frac;
    if ($urandom_range(1) == 0) begin
      return $urandom();
    end
    case ($urandom_range(5))
      0:       frac = 16'h0000;
      1:       frac = 16'h0001;
      2:       frac = 16'hFFFF;
      3:       frac = 16'hFFFE;
      4:       frac = 16'h8000;
      default: frac = 16'($urandom_range(16'hFFFF));
    endcase
    return {16'($urandom_range(16'hFFFF)), frac};
  endfunction

  task automatic wait_for_results();
    while (sb.expected_noise.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  initial begin
    logic [15:0] fx[5];
    logic [15:0] fy[5];
    int unsigned phase_idle[4];
    sb           = new();
    start_i      = 1'b0;
    x_coord_i    = '0;
    y_coord_i    = '0;
    rst_ni       = 1'b0;
    idle_pct     = 0;
    fx = '{16'h0000, 16'hFFFF, 16'h8000, 16'h0000, 16'hFFFF};
    fy = '{16'h0000, 16'hFFFF, 16'h8000, 16'hFFFF, 16'h0000};
    phase_idle = '{0, 80, 6, 0};
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: every gradient base with fractions at zero, one half and the top,
    // then the extremes of the coordinate range.
    for (int b = 0; b < 4; b++) begin
      for (int k = 0; k < 5; k++) begin
        send_point({16'(b), fx[k]}, {16'h0000, fy[k]});
      end
    end
    send_point(32'h7FFF_FFFF, 32'h8000_0000);
    send_point(32'h8000_0000, 32'h7FFF_FFFF);
    send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_point(32'h8000_0000, 32'h8000_0000);

    // Hold the sender back until the pipeline has emptied.
    @(negedge clk_i);
    start_i <= 1'b0;
    wait_for_results();

    // Random phases with differing amounts of sender idling.
    for (int p = 0; p < 4; p++) begin
      idle_pct = phase_idle[p];
      for (int i = 0; i < ItemsPerPhase; i++) begin
        send_point(random_coord(), random_coord());
      end
    end
    @(negedge clk_i);
    start_i <= 1'b0;

    wait_for_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.failures == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/perl_pkg.sv
hdl/perl_fade.sv
hdl/perl_lerp.sv
hdl/perlin_noise_2d_sample.sv
test/tb_top.sv
